// ----- src/koit_pkg.sv -----
package koit_pkg;

  localparam int ENTRIES_DEFAULT = 64;

  localparam int KEY_W    = 32;
  localparam int OFFSET_W = 40;
  localparam int COUNT_W  = 7;

  // operation codes
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FIND   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [KEY_W-1:0] key;
    logic [OFFSET_W-1:0]     offset;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [OFFSET_W-1:0] found_offset;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch the request, perform an add
    logic scan;    // search step
    logic shift;   // compaction step
    logic load;    // move the pending result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_end;
    logic shift_end;
    logic op_find;
  } sts_t;

endpackage

// ----- src/key_offset_index_table.sv -----
// Channel  Handshake               Payload
// req      req_valid / req_ready   req_item (kind, key, offset)
// rsp      rsp_valid / rsp_ready   rsp_item (status, found_offset, entry_count)
//
// One item at a time. After acceptance, add and the unused kind go straight to
// the result; find and remove read the entries in order, a find that hits an
// entry stops there, and remove always walks to the end to compact. The next
// request is taken in the cycle after the load. Synchronous active-high reset
// clears the count, not the memory. A result held by rsp_ready low stalls only
// the load of the next result.
module key_offset_index_table #(
  parameter int ENTRIES = koit_pkg::ENTRIES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  koit_pkg::req_t req_item,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output koit_pkg::rsp_t rsp_item
);

  koit_pkg::cmd_t cmd;
  koit_pkg::sts_t sts;

  koit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_kind  (req_item.kind),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  koit_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_item (req_item),
    .rsp_item (rsp_item),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ----- src/koit_ctrl.sv -----
module koit_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         req_kind,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output koit_pkg::cmd_t     cmd,
  input  koit_pkg::sts_t     sts
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.start = 1'b1;
          if (req_kind == koit_pkg::KIND_REMOVE || req_kind == koit_pkg::KIND_FIND) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_next = sts.op_find ? S_DONE : S_SHIFT;
        end else if (sts.scan_end) begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold the pending result until the output register frees up
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/koit_dp.sv -----
module koit_dp #(
  parameter int ENTRIES = koit_pkg::ENTRIES_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  koit_pkg::req_t  req_item,
  output koit_pkg::rsp_t  rsp_item,
  input  koit_pkg::cmd_t  cmd,
  output koit_pkg::sts_t  sts
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [CW-1:0]                     count;
  logic [1:0]                        op_kind;
  logic signed [koit_pkg::KEY_W-1:0] op_key;
  logic [CW-1:0]                     issue_idx;
  logic                              rd_valid;
  logic [AW-1:0]                     rd_idx;
  logic [1:0]                        res_status;
  logic [koit_pkg::OFFSET_W-1:0]     res_found;

  logic signed [koit_pkg::KEY_W-1:0] mem_key [ENTRIES];
  logic [koit_pkg::OFFSET_W-1:0]     mem_ofs [ENTRIES];
  logic signed [koit_pkg::KEY_W-1:0] rd_key;
  logic [koit_pkg::OFFSET_W-1:0]     rd_ofs;

  logic                              full;
  logic                              add_ok;
  logic                              issue_more;
  logic                              hit;
  logic                              drained;
  logic                              mem_we;
  logic [AW-1:0]                     waddr;
  logic signed [koit_pkg::KEY_W-1:0] wkey;
  logic [koit_pkg::OFFSET_W-1:0]     wofs;
  logic                              mem_re;

  assign full       = (count == CW'(ENTRIES));
  assign add_ok     = cmd.start && req_item.kind == koit_pkg::KIND_ADD && !full;
  assign issue_more = (issue_idx < count);
  assign hit        = rd_valid && (rd_key == op_key);
  assign drained    = !rd_valid && !issue_more;

  assign sts.hit       = hit;
  assign sts.scan_end  = drained;
  assign sts.shift_end = drained;
  assign sts.op_find   = (op_kind == koit_pkg::KIND_FIND);

  // one read and one write per cycle; compaction writes entry i-1 with entry i
  always_comb begin
    mem_we = 1'b0;
    waddr  = count[AW-1:0];
    wkey   = req_item.key;
    wofs   = req_item.offset;
    if (add_ok) begin
      mem_we = 1'b1;
    end else if (cmd.shift && rd_valid) begin
      mem_we = 1'b1;
      waddr  = rd_idx - AW'(1);
      wkey   = rd_key;
      wofs   = rd_ofs;
    end
  end

  assign mem_re = (cmd.scan || cmd.shift) && issue_more;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_key[waddr] <= wkey;
      mem_ofs[waddr] <= wofs;
    end
    if (mem_re) begin
      rd_key <= mem_key[issue_idx[AW-1:0]];
      rd_ofs <= mem_ofs[issue_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_valid  <= 1'b0;
      issue_idx <= '0;
    end else begin
      if (cmd.start) begin
        issue_idx <= '0;
        rd_valid  <= 1'b0;
      end else if (cmd.scan || cmd.shift) begin
        rd_valid <= issue_more;
        if (issue_more) begin
          issue_idx <= issue_idx + CW'(1);
        end
      end
      if (add_ok) begin
        count <= count + CW'(1);
      end else if (cmd.shift && drained) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_idx <= issue_idx[AW-1:0];
    end
    if (cmd.start) begin
      op_kind    <= req_item.kind;
      op_key     <= req_item.key;
      res_found  <= '0;
      res_status <= (req_item.kind == koit_pkg::KIND_ADD && full) ?
                    koit_pkg::ST_FULL : koit_pkg::ST_DONE;
    end else if (cmd.scan) begin
      if (hit) begin
        if (op_kind == koit_pkg::KIND_FIND) begin
          res_found <= rd_ofs;
        end
      end else if (drained) begin
        res_status <= koit_pkg::ST_MISSING;
      end
    end
    if (cmd.load) begin
      rsp_item.status       <= res_status;
      rsp_item.found_offset <= res_found;
      rsp_item.entry_count  <= koit_pkg::COUNT_W'(count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (count == $past(count) || count == $past(count) + CW'(1) ||
              count == $past(count) - CW'(1)))
    else $error("entry count moved by more than one");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (CW'(rd_idx) < count))
    else $error("read of an entry beyond the count");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (CW'(waddr) <= count && CW'(waddr) < CW'(ENTRIES)))
    else $error("write beyond the filled region");

endmodule
